FILE: rtl/edd_pkg.sv
// Shared types and constants of the error diffusion dither block.
package edd_pkg;

    // Field and register widths
    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 11;
    localparam int LEVELS_W   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Width of the rounded level index |round(f * L)|
    localparam int QM_W = 12;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_LEVELS = 1'd1;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [LEVELS_W-1:0] RST_QUANT_LEVELS = 8'd1;

    // Commands from the controller to the datapath, one per step
    typedef struct packed {
        logic load;      // latch the pixel, handle start of frame, read the row store
        logic sum;       // add pixel and incoming error
        logic mul;       // scale by the level count
        logic rnd;       // round to a level index, load the divider
        logic div_step;  // two quotient bits
        logic err;       // quantization error and output value
        logic d5;        // reciprocal products for the two error shares
        logic fin;       // write back error, advance the column, emit result
    } t_cmd;

    // Status seen by the controller
    typedef struct packed {
        logic in_valid;
        logic out_free;
    } t_status;

endpackage

FILE: rtl/edd_ifs.sv
// Valid/ready channel interfaces of the error diffusion dither block.
interface edd_pix_if import edd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_pixel;
    logic             start_of_frame;

    modport source (output valid, output in_pixel, output start_of_frame, input ready);
    modport sink   (input valid, input in_pixel, input start_of_frame, output ready);
endinterface

interface edd_out_if import edd_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;

    modport source (output valid, output out_pixel, input ready);
    modport sink   (input valid, input out_pixel, output ready);
endinterface

interface edd_cfg_if import edd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

FILE: rtl/edd_ctrl.sv
// Step sequencer of the error diffusion dither block.
module edd_ctrl import edd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    // Divider passes: two quotient bits per cycle over the dividend
    localparam int DIV_STEPS = (FRAC_BITS + QM_W + 1) / 2;
    localparam int CNTW      = $clog2(DIV_STEPS);
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(DIV_STEPS - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RND  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ERR  = 3'd5;
    localparam logic [2:0] S_D5   = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            accept;

    assign accept     = i_status.in_valid && (r_state == S_IDLE);
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RND;
            end
            S_RND: begin
                o_cmd.rnd = 1'b1;
                n_cnt     = '0;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == LAST_STEP) begin
                    n_state = S_ERR;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_D5;
            end
            S_D5: begin
                o_cmd.d5 = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // hold until the output register can take the result
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == S_SUM)
        else $error("accepted pixel did not start the sequence");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && !i_status.in_valid |=> r_state == S_IDLE)
        else $error("sequencer left idle without a pixel");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt <= LAST_STEP)
        else $error("divider pass count overran");
    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) && (r_cnt == LAST_STEP) |=> r_state == S_ERR)
        else $error("divider did not finish after its last pass");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin |-> i_status.out_free)
        else $error("result issued while output register was full");
`endif

endmodule

FILE: rtl/edd_dp.sv
// Datapath of the error diffusion dither block: registers, row store, divider.
module edd_dp import edd_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [PIX_W-1:0]      i_pixel,
    input  logic                  i_sof,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic [PIX_W-1:0]      o_res_pixel
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = AW + 1;
    localparam int EW  = FRAC_BITS + 2;          // stored error terms
    localparam int FW  = FRAC_BITS + 4;          // pixel plus incoming error
    localparam int TW  = FRAC_BITS + 12;         // f * L
    localparam int NW  = FRAC_BITS + QM_W;       // divider dividend
    localparam int DVW = NW + (NW % 2);          // padded to whole passes
    localparam int OW  = DVW - (FRAC_BITS - 8);  // quotient scaled to 256
    localparam int YW  = EW + 1;                 // |2e| + 2
    localparam int SH  = YW + 3;                 // reciprocal shift
    localparam int MW  = FRAC_BITS + 4;
    localparam int PW  = YW + MW;
    localparam int QW5 = PW - SH;
    localparam logic [MW-1:0] RECIP5 = MW'(((64'd1 << SH) + 64'd4) / 64'd5);

    // Configuration registers
    logic [WIDTH_W-1:0]  r_cfg_width;
    logic [LEVELS_W-1:0] r_cfg_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RST_IMAGE_WIDTH;
            r_cfg_levels <= RST_QUANT_LEVELS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_QUANT_LEVELS: r_cfg_levels <= i_cfg_data[LEVELS_W-1:0];
            endcase
        end
    end

    // Effective level count and row width
    logic [LEVELS_W-1:0] lv;
    logic [CW-1:0]       w_eff;

    assign lv = (r_cfg_levels == '0) ? LEVELS_W'(1) : r_cfg_levels;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_cfg_width) > 32'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_cfg_width);
        end
    end

    // Row position and error carries
    logic [AW-1:0]        r_col;
    logic                 r_first;
    logic signed [EW-1:0] r_right, r_diag;
    logic [CW-1:0]        col_nxt;
    logic                 wrap;
    logic [AW-1:0]        rd_addr;

    assign col_nxt = {1'b0, r_col} + CW'(1);
    assign wrap    = (col_nxt >= w_eff);
    assign rd_addr = i_sof ? '0 : r_col;

    // Payload registers
    logic [PIX_W-1:0]     r_pix;
    logic signed [EW-1:0] r_mem_q;
    logic signed [FW-1:0] r_f;
    logic signed [TW-1:0] r_t;
    logic [DVW-1:0]       r_dq;
    logic [LEVELS_W-1:0]  r_rem;
    logic                 r_neg, r_pos;
    logic signed [EW-1:0] r_e;
    logic                 r_eneg;
    logic [PW-1:0]        r_p40, r_p20;
    logic [PIX_W-1:0]     r_o;

    // Row error store: no reset, every entry read is written first
    logic signed [EW-1:0] mem [MAX_WIDTH];
    logic signed [EW-1:0] wdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mem_q <= mem[rd_addr];
        end
        if (i_cmd.fin) begin
            mem[r_col] <= wdata;
        end
    end

    // Sum: pixel plus right carry plus error from the row above (none in the first row)
    logic [FW-1:0]        pix_x;
    logic signed [FW-1:0] right_x, mem_x, f_sum;

    assign pix_x   = FW'({r_pix, {(FRAC_BITS - 8){1'b0}}});
    assign right_x = FW'(r_right);
    assign mem_x   = FW'(r_mem_q);
    assign f_sum   = pix_x + right_x + (r_first ? '0 : mem_x);

    // Scale by the level count
    logic signed [TW-1:0] t_mul;
    assign t_mul = r_f * $signed({1'b0, lv});

    // Round half away from zero to a level index
    logic [TW-1:0]   t_mag, rnd_sum;
    logic [QM_W-1:0] qm;

    assign t_mag   = r_t[TW-1] ? -r_t : r_t;
    assign rnd_sum = t_mag + (TW'(1) << (FRAC_BITS - 1));
    assign qm      = rnd_sum[TW-1:FRAC_BITS];

    // Two restoring division steps per cycle
    logic [LEVELS_W:0]   rem_a, rem_b, rem_a2, rem_b2;
    logic                ge_a, ge_b;
    logic [DVW-1:0]      dq1, dq2;
    logic [LEVELS_W-1:0] rem2;

    always_comb begin
        rem_a  = {r_rem, r_dq[DVW-1]};
        ge_a   = (rem_a >= {1'b0, lv});
        rem_a2 = ge_a ? (rem_a - {1'b0, lv}) : rem_a;
        dq1    = {r_dq[DVW-2:0], ge_a};
        rem_b  = {rem_a2[LEVELS_W-1:0], dq1[DVW-1]};
        ge_b   = (rem_b >= {1'b0, lv});
        rem_b2 = ge_b ? (rem_b - {1'b0, lv}) : rem_b;
        dq2    = {dq1[DVW-2:0], ge_b};
        rem2   = rem_b2[LEVELS_W-1:0];
    end

    // Error and output value; the true error fits EW bits, so wrap is exact
    logic [LEVELS_W:0] rnd_rem;
    logic              inc;
    logic [EW-1:0]     f_lo, d_lo, inc_x, e_val;
    logic [OW-1:0]     d_hi;
    logic [PIX_W-1:0]  o_val;

    always_comb begin
        rnd_rem = {1'b0, r_rem} + {2'b00, lv[LEVELS_W-1:1]};
        inc     = (rnd_rem >= {1'b0, lv});
        f_lo    = r_f[EW-1:0];
        d_lo    = r_dq[EW-1:0];
        inc_x   = EW'(inc);
        e_val   = r_neg ? (f_lo + d_lo + inc_x) : (f_lo - d_lo - inc_x);
        d_hi    = r_dq[DVW-1:FRAC_BITS-8];
        if (!r_pos) begin
            o_val = '0;
        end else if (|d_hi[OW-1:PIX_W]) begin
            o_val = '1;
        end else begin
            o_val = d_hi[PIX_W-1:0];
        end
    end

    // Magnitudes plus two, times the reciprocal of five
    logic [YW-1:0] e2, e1, y2, y1;
    logic [PW-1:0] p40, p20;

    always_comb begin
        e2  = {r_e, 1'b0};
        e1  = YW'(r_e);
        y2  = r_e[EW-1] ? (~e2 + YW'(3)) : (e2 + YW'(2));
        y1  = r_e[EW-1] ? (~e1 + YW'(3)) : (e1 + YW'(2));
        p40 = y2 * RECIP5;
        p20 = y1 * RECIP5;
    end

    // Signed shares and the store entry
    logic [QW5-1:0]       q40, q20;
    logic [EW-1:0]        q40x, q20x;
    logic signed [EW-1:0] e40, e20;

    always_comb begin
        q40   = r_p40[PW-1:SH];
        q20   = r_p20[PW-1:SH];
        q40x  = EW'(q40);
        q20x  = EW'(q20);
        e40   = r_eneg ? -q40x : q40x;
        e20   = r_eneg ? -q20x : q20x;
        wdata = e40 + r_diag;
    end

    // Step registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix <= i_pixel;
        end
        if (i_cmd.sum) begin
            r_f <= f_sum;
        end
        if (i_cmd.mul) begin
            r_t <= t_mul;
        end
        if (i_cmd.rnd) begin
            r_dq  <= DVW'({qm, {FRAC_BITS{1'b0}}});
            r_rem <= '0;
            r_neg <= r_t[TW-1];
            r_pos <= !r_t[TW-1] && (qm != '0);
        end else if (i_cmd.div_step) begin
            r_dq  <= dq2;
            r_rem <= rem2;
        end
        if (i_cmd.err) begin
            r_e <= e_val;
            r_o <= o_val;
        end
        if (i_cmd.d5) begin
            r_p40  <= p40;
            r_p20  <= p20;
            r_eneg <= r_e[EW-1];
        end
    end

    // Row position and carries: clear on start of frame and at row end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_first <= 1'b1;
            r_right <= '0;
            r_diag  <= '0;
        end else if (i_cmd.load && i_sof) begin
            r_col   <= '0;
            r_first <= 1'b1;
            r_right <= '0;
            r_diag  <= '0;
        end else if (i_cmd.fin) begin
            if (wrap) begin
                r_col   <= '0;
                r_first <= 1'b0;
                r_right <= '0;
                r_diag  <= '0;
            end else begin
                r_col   <= col_nxt[AW-1:0];
                r_right <= e40;
                r_diag  <= e20;
            end
        end
    end

    assign o_res_pixel = r_o;

endmodule

FILE: rtl/error_diffusion_dither.sv
// Top level of the error diffusion dither block.
//
//  channel  | direction | payload                      | accepted when
//  i_pix    | in        | in_pixel[7:0], start_of_frame | valid & ready
//  o_pix    | out       | out_pixel[7:0]                | valid & ready
//  i_cfg    | in        | reg_index[0], wr_data[10:0]   | valid & ready (ready tied high)
//
// A pixel passes through the accept step, three setup steps, the passes of the radix-4
// level-count divider and three closing steps; the next pixel is taken only after the last
// closing step of the one before.
// Reset clears control state and the carries; the row store needs no clearing pass.
// A finished result waits in the output register while the next pixel is taken;
// the write-back step holds only if that register is still full.
module error_diffusion_dither import edd_pkg::*; #(
    parameter int MAX_WIDTH = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    edd_pix_if.sink   i_pix,
    edd_out_if.source o_pix,
    edd_cfg_if.sink   i_cfg
);

    t_cmd             cmd;
    t_status          status;
    logic [PIX_W-1:0] res_pixel;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;

    assign status.in_valid = i_pix.valid;
    assign status.out_free = !r_out_valid || o_pix.ready;
    assign i_cfg.ready     = 1'b1;

    edd_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (status),
        .o_in_ready (i_pix.ready),
        .o_cmd      (cmd)
    );

    edd_dp #(
        .MAX_WIDTH (MAX_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_pixel     (i_pix.in_pixel),
        .i_sof       (i_pix.start_of_frame),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_idx   (i_cfg.reg_index),
        .i_cfg_data  (i_cfg.wr_data),
        .o_res_pixel (res_pixel)
    );

    // Output register: load on write-back, drop when the beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.fin) begin
            r_out_pixel <= res_pixel;
        end
    end

    assign o_pix.valid     = r_out_valid;
    assign o_pix.out_pixel = r_out_pixel;

endmodule
